// ----- rtl/cht_pkg.sv -----
`timescale 1ns / 1ps

package cht_pkg;

  localparam int DATA_W   = 32;
  localparam int HANDLE_W = 8;
  localparam int HINT_W   = 9;
  // Width used for index arithmetic; covers the largest supported table.
  localparam int XW       = 16;
  // The valid bitmap is kept in rows of ROW_W marks.
  localparam int ROW_W    = 32;
  localparam int ROW_BW   = 5;

  localparam logic [1:0] OPC_GRANT  = 2'd0;
  localparam logic [1:0] OPC_CLOSE  = 2'd1;
  localparam logic [1:0] OPC_LOOKUP = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RIGHTS    = 3'd1,
    ST_FULL      = 3'd2,
    ST_BADHANDLE = 3'd3,
    ST_STALE     = 3'd4,
    ST_DENIED    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_REPLY
  } state_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   handle;
    logic [DATA_W-1:0]     object;
    logic                  acquire;
    logic                  drop;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] object;
    logic [DATA_W-1:0] rights;
    logic [DATA_W-1:0] generation;
  } entry_t;

  // Read and write strobes of the valid bitmap.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } vm_cmd_t;

  typedef struct packed {
    logic              found;
    logic [ROW_BW-1:0] idx;
  } find_t;

  // Lowest set bit of a row.
  function automatic find_t lowest_set(input logic [ROW_W-1:0] w);
    find_t r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.found = 1'b1;
        r.idx   = ROW_BW'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/cht_valid_map.sv -----
`timescale 1ns / 1ps

module cht_valid_map #(
  parameter int NROWS = 8,
  parameter int RW    = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cht_pkg::vm_cmd_t            cmd,
  input  logic [RW-1:0]               rd_row,
  input  logic [RW-1:0]               wr_row,
  input  logic [cht_pkg::ROW_W-1:0]   wr_data,
  output logic [cht_pkg::ROW_W-1:0]   rd_data
);

  logic [cht_pkg::ROW_W-1:0] row_mem [NROWS];
  logic [NROWS-1:0]          row_live;
  logic [cht_pkg::ROW_W-1:0] rd_raw;
  logic                      rd_live;

  // A row never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_live <= '0;
    end else if (cmd.wr_en) begin
      row_live[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      row_mem[wr_row] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_raw  <= row_mem[rd_row];
      rd_live <= row_live[rd_row];
    end
  end

  assign rd_data = rd_live ? rd_raw : '0;

endmodule

// ----- rtl/capability_handle_table.sv -----
`timescale 1ns / 1ps

// Capability handle table. Each slot holds an object id, a rights mask and
// the object generation seen at grant; the valid marks live in a bitmap
// memory of 32-bit rows and the slot payload in a second memory, both with
// registered reads. Grant (opcode 0) rejects rights outside the type's
// defaults, then scans the bitmap one row per cycle from a rotating hint,
// wrapping once, and claims the first free slot at or after the hint.
// Close (opcode 1) frees a valid slot and raises release_object. Lookup
// (opcode 2) frees a slot whose generation is stale (release_object), denies
// missing rights, and otherwise returns the object with acquire_object. The
// block works on one item at a time: close and lookup check the slot in
// S_CHECK, rejected items reply from S_REPLY, and a grant holds the input
// while it scans, one row per read of the single bitmap read port. A
// finished result waits in an output register, so the next item may
// transfer while it is pending. The table is empty right after reset; no
// clearing pass is needed.
module capability_handle_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  handle,
  input  logic [31:0] object_id,
  input  logic [31:0] object_generation,
  input  logic [31:0] rights,
  input  logic [31:0] type_rights,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  result_handle,
  output logic [31:0] result_object,
  output logic        acquire_object,
  output logic        release_object
);

  localparam int ROW_W     = cht_pkg::ROW_W;
  localparam int ROW_BW    = cht_pkg::ROW_BW;
  localparam int XW        = cht_pkg::XW;
  localparam int NROWS     = (TABLE_DEPTH + ROW_W - 1) / ROW_W;
  localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int KW        = $clog2(NROWS + 1);
  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int LAST_BITS = TABLE_DEPTH - (NROWS - 1) * ROW_W;
  // Marks past the end of the table in the last row count as taken.
  localparam logic [ROW_W-1:0] LAST_MASK = {ROW_W{1'b1}} >> (ROW_W - LAST_BITS);

  // Captured request.
  logic [1:0]                    req_opcode;
  logic [7:0]                    req_handle;
  logic [31:0]                   req_object;
  logic [31:0]                   req_generation;
  logic [31:0]                   req_rights;

  // Control state.
  cht_pkg::state_t               state, state_next;
  logic [cht_pkg::HINT_W-1:0]    hint, hint_next;
  logic [RW-1:0]                 cur_row, cur_row_next;
  logic [KW-1:0]                 visit, visit_next;
  cht_pkg::result_t              res_hold, res_hold_next;
  cht_pkg::result_t              out_res, res_d;
  logic                          load_out;
  logic                          capture;
  logic                          out_free;

  // Bitmap memory port.
  cht_pkg::vm_cmd_t              vm_cmd;
  logic [RW-1:0]                 vm_rd_row;
  logic [RW-1:0]                 vm_wr_row;
  logic [ROW_W-1:0]              vm_wr_data;
  logic [ROW_W-1:0]              vm_rd_data;

  // Slot payload memory.
  cht_pkg::entry_t               entry_mem [TABLE_DEPTH];
  cht_pkg::entry_t               ent_rdata;
  cht_pkg::entry_t               ent_wdata;
  logic                          ent_rd_en;
  logic                          ent_wr_en;
  logic [AW-1:0]                 ent_rd_addr;
  logic [AW-1:0]                 ent_wr_addr;

  // Address arithmetic.
  logic [XW-1:0]                 start_x;
  logic [XW-1:0]                 start_row_x;
  logic [RW-1:0]                 start_row;
  logic [ROW_BW-1:0]             start_bit;
  logic [XW-1:0]                 handle_x;
  logic [XW-1:0]                 handle_row_x;
  logic                          handle_in_range;
  logic                          grant_rights_ok;
  logic [RW-1:0]                 cur_row_inc;
  logic [ROW_W-1:0]              range_mask;
  logic [ROW_W-1:0]              win_mask;
  logic [ROW_W-1:0]              free_bits;
  cht_pkg::find_t                find;
  logic [XW-1:0]                 idx_x;
  logic [XW-1:0]                 idx_plus;
  logic [ROW_W-1:0]              handle_onehot;
  logic                          slot_valid;

  assign out_free = !out_valid || out_ready;

  // Search start: the hint, wrapped to zero once it reaches the table depth.
  assign start_x     = (XW'(hint) >= XW'(TABLE_DEPTH)) ? '0 : XW'(hint);
  assign start_row_x = start_x >> ROW_BW;
  assign start_row   = start_row_x[RW-1:0];
  assign start_bit   = start_x[ROW_BW-1:0];

  assign handle_x        = XW'(handle);
  assign handle_row_x    = handle_x >> ROW_BW;
  assign handle_in_range = handle_x < XW'(TABLE_DEPTH);
  assign grant_rights_ok = (rights & type_rights) == rights;

  // Scan window: first visit covers the hint row from the hint upward, the
  // closing visit covers the same row below the hint.
  assign cur_row_inc = (cur_row == RW'(NROWS - 1)) ? '0 : cur_row + 1'b1;
  assign range_mask  = (cur_row == RW'(NROWS - 1)) ? LAST_MASK : '1;
  always_comb begin
    if (visit == '0) begin
      win_mask = {ROW_W{1'b1}} << start_bit;
    end else if (visit == KW'(NROWS)) begin
      win_mask = ~({ROW_W{1'b1}} << start_bit);
    end else begin
      win_mask = '1;
    end
  end
  assign free_bits = ~vm_rd_data & range_mask & win_mask;
  assign find      = cht_pkg::lowest_set(free_bits);
  assign idx_x     = (XW'(cur_row) << ROW_BW) | XW'(find.idx);
  assign idx_plus  = idx_x + 1'b1;

  assign handle_onehot = ROW_W'(1) << req_handle[ROW_BW-1:0];
  assign slot_valid    = vm_rd_data[req_handle[ROW_BW-1:0]];

  assign ent_wdata.object     = req_object;
  assign ent_wdata.rights     = req_rights;
  assign ent_wdata.generation = req_generation;
  assign ent_rd_addr          = handle_x[AW-1:0];
  assign ent_wr_addr          = idx_x[AW-1:0];

  always_comb begin
    state_next    = state;
    hint_next     = hint;
    cur_row_next  = cur_row;
    visit_next    = visit;
    res_hold_next = res_hold;
    res_d         = '0;
    load_out      = 1'b0;
    capture       = 1'b0;
    in_ready      = 1'b0;
    vm_cmd        = '0;
    vm_rd_row     = cur_row;
    vm_wr_row     = cur_row;
    vm_wr_data    = '0;
    ent_rd_en     = 1'b0;
    ent_wr_en     = 1'b0;
    case (state)
      cht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          capture = 1'b1;
          res_hold_next        = '0;
          res_hold_next.status = cht_pkg::ST_BADHANDLE;
          if (opcode == cht_pkg::OPC_GRANT) begin
            if (grant_rights_ok) begin
              // Fetch the hint row and start the scan.
              vm_cmd.rd_en = 1'b1;
              vm_rd_row    = start_row;
              cur_row_next = start_row;
              visit_next   = '0;
              state_next   = cht_pkg::S_SCAN;
            end else begin
              res_hold_next.status = cht_pkg::ST_RIGHTS;
              state_next           = cht_pkg::S_REPLY;
            end
          end else if ((opcode inside {cht_pkg::OPC_CLOSE, cht_pkg::OPC_LOOKUP})
                       && handle_in_range) begin
            vm_cmd.rd_en = 1'b1;
            vm_rd_row    = handle_row_x[RW-1:0];
            cur_row_next = handle_row_x[RW-1:0];
            ent_rd_en    = 1'b1;
            state_next   = cht_pkg::S_CHECK;
          end else begin
            state_next = cht_pkg::S_REPLY;
          end
        end
      end
      cht_pkg::S_REPLY: begin
        res_d = res_hold;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_CHECK: begin
        // Memory outputs hold until the next read, so a stalled output waits here.
        vm_wr_data = vm_rd_data & ~handle_onehot;
        if (!slot_valid) begin
          res_d.status = cht_pkg::ST_BADHANDLE;
        end else if (req_opcode == cht_pkg::OPC_CLOSE) begin
          res_d.status = cht_pkg::ST_OK;
          res_d.object = ent_rdata.object;
          res_d.drop   = 1'b1;
          vm_cmd.wr_en = out_free;
        end else if (ent_rdata.generation != req_generation) begin
          res_d.status = cht_pkg::ST_STALE;
          res_d.object = ent_rdata.object;
          res_d.drop   = 1'b1;
          vm_cmd.wr_en = out_free;
        end else if ((ent_rdata.rights & req_rights) != req_rights) begin
          res_d.status = cht_pkg::ST_DENIED;
        end else begin
          res_d.status  = cht_pkg::ST_OK;
          res_d.object  = ent_rdata.object;
          res_d.acquire = 1'b1;
        end
        if (out_free) begin
          load_out   = 1'b1;
          state_next = cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_SCAN: begin
        vm_wr_data = vm_rd_data | (ROW_W'(1) << find.idx);
        if (find.found) begin
          res_d.status  = cht_pkg::ST_OK;
          res_d.handle  = idx_x[cht_pkg::HANDLE_W-1:0];
          res_d.object  = req_object;
          res_d.acquire = 1'b1;
          if (out_free) begin
            load_out     = 1'b1;
            vm_cmd.wr_en = 1'b1;
            ent_wr_en    = 1'b1;
            hint_next    = idx_plus[cht_pkg::HINT_W-1:0];
            state_next   = cht_pkg::S_IDLE;
          end
        end else if (visit == KW'(NROWS)) begin
          res_d.status = cht_pkg::ST_FULL;
          if (out_free) begin
            load_out   = 1'b1;
            state_next = cht_pkg::S_IDLE;
          end
        end else begin
          // Advance to the next row, wrapping at the end of the table.
          visit_next   = visit + 1'b1;
          cur_row_next = cur_row_inc;
          vm_cmd.rd_en = 1'b1;
          vm_rd_row    = cur_row_inc;
        end
      end
      default: begin
        state_next = cht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cht_pkg::S_IDLE;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      hint  <= hint_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    cur_row  <= cur_row_next;
    visit    <= visit_next;
    res_hold <= res_hold_next;
    if (capture) begin
      req_opcode     <= opcode;
      req_handle     <= handle;
      req_object     <= object_id;
      req_generation <= object_generation;
      req_rights     <= rights;
    end
    if (load_out) begin
      out_res <= res_d;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_wr_en) begin
      entry_mem[ent_wr_addr] <= ent_wdata;
    end
    if (ent_rd_en) begin
      ent_rdata <= entry_mem[ent_rd_addr];
    end
  end

  cht_valid_map #(
    .NROWS (NROWS),
    .RW    (RW)
  ) u_valid_map (
    .clk     (clk),
    .rst     (rst),
    .cmd     (vm_cmd),
    .rd_row  (vm_rd_row),
    .wr_row  (vm_wr_row),
    .wr_data (vm_wr_data),
    .rd_data (vm_rd_data)
  );

  assign status         = out_res.status;
  assign result_handle  = out_res.handle;
  assign result_object  = out_res.object;
  assign acquire_object = out_res.acquire;
  assign release_object = out_res.drop;

  a_acq_rel_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(acquire_object && release_object))
    else $error("acquire and release raised together");

  a_visit_bound: assert property (@(posedge clk) disable iff (rst)
    state == cht_pkg::S_SCAN |-> visit <= KW'(NROWS))
    else $error("scan went past one full wrap");

  a_grant_writes: assert property (@(posedge clk) disable iff (rst)
    (load_out && state == cht_pkg::S_SCAN && res_d.status == cht_pkg::ST_OK)
      |-> (ent_wr_en && vm_cmd.wr_en))
    else $error("granted slot not stored");

  a_handle_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != cht_pkg::ST_OK) |-> result_handle == '0)
    else $error("handle reported on a failed item");

endmodule
